FILE: rtl/dprq_pkg.sv
// dprq_pkg: types and constants shared by the delayed priority request queue
// depends on nothing
package dprq_pkg;

    localparam int DEPTH     = 32;
    localparam int TAG_BITS  = 8;
    localparam int TIME_BITS = 32;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_DELIVERED = 3'd0,
        K_DISCARDED = 3'd1,
        K_EMPTY     = 3'd2,
        K_NOT_READY = 3'd3,
        K_STOPPED   = 3'd4,
        K_PUSH_OK   = 3'd5,
        K_PUSH_FULL = 3'd6
    } t_kind;

    typedef struct packed {
        logic [1:0]           op;
        logic [TAG_BITS-1:0]  req_tag;
        logic [7:0]           prio_in;
        logic [TIME_BITS-1:0] ready_in;
        logic [TIME_BITS-1:0] now_ticks;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]           kind;
        logic [TAG_BITS-1:0]  tag_out;
        logic [7:0]           prio_out;
        logic [TIME_BITS-1:0] ready_out;
        logic [TIME_BITS-1:0] wait_ticks;
        logic [5:0]           occupancy;
        logic                 is_empty;
        logic                 last;
    } t_out_beat;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [7:0]           prio;
        logic [TIME_BITS-1:0] ready;
        logic                 cancelled;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic                 ins;
        logic                 shl;
        logic                 cancel;
        t_entry               new_entry;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_OUT
    } t_state;

    function automatic logic beats(t_entry a, t_entry b);
        if (a.prio != b.prio) return a.prio > b.prio;
        return a.ready < b.ready;
    endfunction

endpackage

FILE: rtl/dprq_cell.sv
// dprq_cell: one slot of the sorted request chain
// depends on dprq_pkg
module dprq_cell
    import dprq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_here_valid,
    input  t_entry    i_left,
    input  logic      i_left_valid,
    input  logic      i_left_beaten,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_beaten
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry  = r_entry;
    // new entry goes at or before this slot
    assign o_beaten = !i_here_valid || beats(i_cmd.new_entry, r_entry);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (o_beaten) begin
                if (i_left_valid && i_left_beaten) n_entry = i_left;
                else if (!i_left_valid || !i_left_beaten) n_entry = i_cmd.new_entry;
            end
            if (o_beaten && i_left_valid && !i_left_beaten) n_entry = i_cmd.new_entry;
        end else if (i_cmd.shl) begin
            n_entry = i_right;
        end else if (i_cmd.cancel && i_here_valid && r_entry.tag == i_cmd.new_entry.tag) begin
            n_entry.cancelled = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/delayed_priority_request_queue.sv
// delayed_priority_request_queue: top level, control and chain of cells
// depends on dprq_pkg and dprq_cell
//
//  channel | dir | handshake           | payload
//  in      | in  | i_valid / o_ready   | i_in   (t_in_beat)
//  out     | out | o_valid / i_ready   | o_out  (t_out_beat)
//  cfg     | in  | i_cfg_we            | i_cfg_data (stopped)
//
// push or pop with no discard: accept in S_IDLE, then S_WORK, then one output beat in S_OUT
// each cancelled entry a pop discards adds another S_WORK pass and another output beat
// cancel and unused op: accept and S_WORK, no beat
// every cell updates in parallel each cycle, so cost does not depend on count
// i_rst_n synchronous active low clears count, state and stopped
// a stalled output beat holds all work until taken
module delayed_priority_request_queue
    import dprq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    t_state              r_state, n_state;
    t_in_beat            r_req;
    t_out_beat           r_out, n_out;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                r_stopped;
    t_cell_cmd           w_cmd;
    t_entry              w_ent [DEPTH];
    logic                w_beat [DEPTH];
    t_entry              w_req_entry;
    t_entry              w_front;

    assign w_req_entry = '{tag: r_req.req_tag, prio: r_req.prio_in,
                           ready: r_req.ready_in, cancelled: 1'b0};
    assign w_front = w_ent[0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_l;
            t_entry w_r;
            logic   w_lv, w_lb;
            if (g == 0) begin : g_first
                assign w_l  = w_req_entry;
                assign w_lv = 1'b0;
                assign w_lb = 1'b0;
            end else begin : g_mid
                assign w_l  = w_ent[g-1];
                assign w_lv = (CNT_BITS'(g - 1) < r_count);
                assign w_lb = w_beat[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_r = w_ent[g];
            end else begin : g_inner
                assign w_r = w_ent[g+1];
            end
            dprq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_here_valid (CNT_BITS'(g) < r_count),
                .i_left       (w_l),
                .i_left_valid (w_lv),
                .i_left_beaten(w_lb),
                .i_right      (w_r),
                .o_entry      (w_ent[g]),
                .o_beaten     (w_beat[g])
            );
        end
    endgenerate

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_out   = r_out;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_out   = r_out;
        w_cmd   = '{ins: 1'b0, shl: 1'b0, cancel: 1'b0, new_entry: w_req_entry};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_WORK;
            end
            S_WORK: begin
                n_out = '0;
                n_out.last = 1'b1;
                n_state = S_OUT;
                case (r_req.op)
                    OP_PUSH: begin
                        n_out.tag_out   = r_req.req_tag;
                        n_out.prio_out  = r_req.prio_in;
                        n_out.ready_out = r_req.ready_in;
                        if (r_count == CNT_BITS'(DEPTH)) begin
                            n_out.kind = K_PUSH_FULL;
                        end else begin
                            w_cmd.ins = 1'b1;
                            n_count = r_count + 1'b1;
                            n_out.kind = K_PUSH_OK;
                        end
                    end
                    OP_POP: begin
                        if (r_stopped) begin
                            n_out.kind = K_STOPPED;
                        end else if (r_count == '0) begin
                            n_out.kind = K_EMPTY;
                        end else begin
                            n_out.tag_out   = w_front.tag;
                            n_out.prio_out  = w_front.prio;
                            n_out.ready_out = w_front.ready;
                            if (w_front.cancelled) begin
                                n_out.kind = K_DISCARDED;
                                n_out.last = 1'b0;
                                w_cmd.shl = 1'b1;
                                n_count = r_count - 1'b1;
                            end else if (w_front.ready <= r_req.now_ticks) begin
                                n_out.kind = K_DELIVERED;
                                w_cmd.shl = 1'b1;
                                n_count = r_count - 1'b1;
                            end else begin
                                n_out.kind = K_NOT_READY;
                                n_out.wait_ticks = w_front.ready - r_req.now_ticks;
                            end
                        end
                    end
                    OP_CANCEL: begin
                        w_cmd.cancel = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
                n_out.occupancy = 6'(n_count);
                n_out.is_empty  = (n_count == '0);
            end
            S_OUT: begin
                if (i_ready) n_state = r_out.last ? S_IDLE : S_WORK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) r_stopped <= i_cfg_data;
        end
        if (r_state == S_IDLE && i_valid) r_req <= i_in;
        r_out <= n_out;
    end

endmodule
